FILE: rtl/core/huffman_code_bit_packer_top_defines.svh
// Assertion macros shared by the checker of the Huffman code bit packer.
// Each macro samples on clk_i; the checker that uses them provides it.
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_DEFINES_SVH

// Property that is checked only outside reset.
`define HCBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that is checked at every edge, reset included.
`define HCBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/hcbp_pkg.sv
// Types and constants of the Huffman code bit packer.
// Used by huffman_code_bit_packer_top, hcbp_checker and the testbench; no dependencies.
package hcbp_pkg;

  // Operation codes of the func field
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ENCODE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

endpackage

FILE: rtl/core/hcbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hcbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/huffman_code_bit_packer_top.sv
// Huffman code bit packer, top level.
// Depends on hcbp_pkg and hcbp_ram.
//
// Accepts one input transaction per cycle. A load writes the code store at
// the accept edge; an encode reads the store at the accept edge and, in the
// lookup stage, appends the code to the pending bits and hands the completed
// bytes (0 to 4) to the output register, which shows them one byte per cycle
// unless the receiver stalls and flags the final byte of the transaction
// with last. A flush emits the pending bits, zero padded, as one byte if any
// bits are pending. The first byte passes through the lookup stage and the
// output register after its input is accepted. Input stalls only while an
// item with bytes to send waits for the output register to drain the
// previous item's bytes, so the sustained item rate is limited by the single
// byte-wide output register. The code store is a RAM of SYMBOL_COUNT entries
// with one valid flop per entry cleared by reset; there is no clearing pass.
module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hcbp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hcbp_pkg::out_t out_data_o
);

  localparam int LenCap = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
  localparam int LenW   = $clog2(LenCap + 1);
  localparam int CodeW  = LenCap;
  localparam int AddrW  = $clog2(SYMBOL_COUNT);
  localparam int EntW   = LenW + CodeW;

  // Input side
  logic             in_acc;
  logic             sym_ok;
  logic [AddrW-1:0] addr;
  logic [LenW-1:0]  cap_len;
  logic             mem_we;
  logic             mem_re;
  logic [EntW-1:0]  mem_rdata;

  // Per-entry valid flops
  logic [SYMBOL_COUNT-1:0] vld_q;

  // Lookup stage
  logic       s1_vld_q, s1_vld_d;
  logic [1:0] s1_func_q;
  logic       s1_hit_q;

  // Pending bits, left aligned (oldest bit in bit 6)
  logic [6:0] pend_q, pend_d;
  logic [2:0] pcnt_q, pcnt_d;

  // Output register with byte queue
  logic [31:0] em_buf_q, em_buf_d;
  logic [2:0]  em_cnt_q, em_cnt_d;

  logic [LenW-1:0]  rd_len;
  logic [CodeW-1:0] rd_code;
  logic [5:0]       len;
  logic [31:0]      code_left;
  logic [39:0]      aligned;
  logic [5:0]       total;
  logic [2:0]       enc_n;
  logic [6:0]       enc_pend;
  logic [2:0]       s1_n;
  logic [31:0]      s1_buf;
  logic             em_free;
  logic             out_acc;
  logic             s1_done;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign sym_ok  = {1'b0, in_data_i.symbol} < 9'(SYMBOL_COUNT);
  assign addr    = in_data_i.symbol[AddrW-1:0];
  assign cap_len = (in_data_i.code_length > 6'(LenCap)) ? LenW'(LenCap)
                                                        : in_data_i.code_length[LenW-1:0];
  assign mem_we  = in_acc && sym_ok && (in_data_i.func == hcbp_pkg::FUNC_LOAD);
  assign mem_re  = in_acc && (in_data_i.func == hcbp_pkg::FUNC_ENCODE);

  hcbp_ram #(
    .Width (EntW),
    .Depth (SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr),
    .wdata_i ({cap_len, in_data_i.code_bits[CodeW-1:0]}),
    .re_i    (mem_re),
    .raddr_i (addr),
    .rdata_o (mem_rdata)
  );

  assign rd_len  = mem_rdata[CodeW +: LenW];
  assign rd_code = mem_rdata[CodeW-1:0];

  // Append the code behind the pending bits, all left aligned in 40 bits
  assign len       = s1_hit_q ? 6'(rd_len) : 6'd0;
  assign code_left = 32'(rd_code) << (6'd32 - len);
  assign aligned   = {pend_q, 33'b0} | ({code_left, 8'b0} >> pcnt_q);
  assign total     = 6'(pcnt_q) + len;
  assign enc_n     = total[5:3];

  // Pick the leftover bits behind the last whole byte
  always_comb begin
    case (enc_n)
      3'd0:    enc_pend = aligned[39:33];
      3'd1:    enc_pend = aligned[31:25];
      3'd2:    enc_pend = aligned[23:17];
      3'd3:    enc_pend = aligned[15:9];
      default: enc_pend = aligned[7:1];
    endcase
  end

  // Decode what the lookup stage emits and how pending bits move
  always_comb begin
    s1_n   = 3'd0;
    s1_buf = aligned[39:8];
    pend_d = pend_q;
    pcnt_d = pcnt_q;
    unique case (s1_func_q)
      hcbp_pkg::FUNC_ENCODE: begin
        s1_n   = enc_n;
        pend_d = enc_pend;
        pcnt_d = total[2:0];
      end
      hcbp_pkg::FUNC_FLUSH: begin
        s1_n   = (pcnt_q != 3'd0) ? 3'd1 : 3'd0;
        s1_buf = {pend_q, 25'b0};
        pend_d = 7'd0;
        pcnt_d = 3'd0;
      end
      default: begin
        s1_n = 3'd0;
      end
    endcase
  end

  assign em_free    = (em_cnt_q == 3'd0) || ((em_cnt_q == 3'd1) && !out_stall_i);
  assign s1_done    = s1_vld_q && ((s1_n == 3'd0) || em_free);
  assign in_stall_o = s1_vld_q && !s1_done;

  // Advance the lookup stage
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_acc) begin
      s1_vld_d = 1'b1;
    end else if (s1_done) begin
      s1_vld_d = 1'b0;
    end
  end

  // Load new bytes or shift out the accepted one
  always_comb begin
    em_buf_d = em_buf_q;
    em_cnt_d = em_cnt_q;
    if (s1_done && (s1_n != 3'd0)) begin
      em_buf_d = s1_buf;
      em_cnt_d = s1_n;
    end else if (out_acc) begin
      em_buf_d = {em_buf_q[23:0], 8'b0};
      em_cnt_d = em_cnt_q - 3'd1;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      em_cnt_q <= 3'd0;
      pend_q   <= 7'd0;
      pcnt_q   <= 3'd0;
      vld_q    <= '0;
    end else begin
      s1_vld_q <= s1_vld_d;
      em_cnt_q <= em_cnt_d;
      if (s1_done) begin
        pend_q <= pend_d;
        pcnt_q <= pcnt_d;
      end
      if (mem_we) begin
        vld_q[addr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    em_buf_q <= em_buf_d;
    if (in_acc) begin
      s1_func_q <= in_data_i.func;
      s1_hit_q  <= sym_ok && vld_q[addr];
    end
  end

  assign out_valid_o         = em_cnt_q != 3'd0;
  assign out_data_o.out_byte = em_buf_q[31:24];
  assign out_data_o.last     = em_cnt_q == 3'd1;

endmodule

FILE: rtl/core/hcbp_checker.sv
// Port-level checker of the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer_top_defines.svh.
`include "huffman_code_bit_packer_top_defines.svh"

module hcbp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input hcbp_pkg::out_t out_data_o
);

  // A stalled result holds
  `HCBP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled output changed")

  // More bytes of the same transaction follow a byte without last
  `HCBP_ASSERT(a_burst_cont, out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o, "byte burst broken before last")

  // Input stalls only behind bytes still waiting to leave
  `HCBP_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o, "input stalled with empty output")

  // Nothing is shown during reset
  `HCBP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o && !in_stall_o, "activity during reset")

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (.*);

FILE: test/testbench.sv
// Self-checking testbench for huffman_code_bit_packer_top.
// Depends on hcbp_pkg for the transaction types and operation codes.
// A scoreboard class predicts the packed bytes and checks them in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int LENGTH_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 320;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 8;

  // Predicts the byte stream and checks emitted transactions against it
  class packed_byte_scoreboard;
    logic [31:0] code_word [256];
    logic [5:0]  code_len [256];
    logic [6:0]  pend_bits;
    int unsigned pend_count;
    out_t        expected_bytes [$];
    int unsigned errors;

    function new();
      foreach (code_word[i]) begin
        code_word[i] = '0;
        code_len[i]  = '0;
      end
      pend_bits  = '0;
      pend_count = 0;
      errors     = 0;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function int unsigned outstanding();
      return expected_bytes.size();
    endfunction

    // Update the code table and pending bits, queue the bytes this item emits
    function void note_accepted_item(in_t item);
      logic [63:0] acc;
      int unsigned len;
      int unsigned total;
      out_t        b;
      case (item.func)
        FUNC_LOAD: begin
          if (item.symbol < SYMBOL_COUNT) begin
            len = item.code_length;
            if (len > LENGTH_CAP) len = LENGTH_CAP;
            code_word[item.symbol] = item.code_bits;
            code_len[item.symbol]  = 6'(len);
          end
        end
        FUNC_ENCODE: begin
          len = (item.symbol < SYMBOL_COUNT) ? code_len[item.symbol] : 0;
          if (len != 0) begin
            acc = ({57'd0, pend_bits} << len) |
                  ({32'd0, code_word[item.symbol]} & ((64'd1 << len) - 64'd1));
            total = pend_count + len;
            while (total >= 8) begin
              total -= 8;
              b.out_byte = 8'(acc >> total);
              b.last     = (total < 8);
              expected_bytes.push_back(b);
            end
            pend_count = total;
            pend_bits  = 7'(acc & ((64'd1 << pend_count) - 64'd1));
          end
        end
        FUNC_FLUSH: begin
          if (pend_count != 0) begin
            b.out_byte = 8'({1'b0, pend_bits} << (8 - pend_count));
            b.last     = 1'b1;
            expected_bytes.push_back(b);
            pend_bits  = '0;
            pend_count = 0;
          end
        end
        default: begin
          // unused operation: drop
        end
      endcase
    endfunction

    // Compare one emitted byte with the oldest expectation
    task check_emitted_byte(out_t got);
      out_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.last !== want.last)
        report($sformatf("last %0b on byte %02h, want %0b",
                         got.last, got.out_byte, want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  packed_byte_scoreboard board = new();
  logic [7:0] pool [16];
  bit no_gaps;
  bit hold_request;

  huffman_code_bit_packer_top #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic in_t pack_item(logic [1:0] f, logic [7:0] s, logic [31:0] c,
                                    logic [5:0] l);
    in_t it;
    it.func        = f;
    it.symbol      = s;
    it.code_bits   = c;
    it.code_length = l;
    return it;
  endfunction

  // Mostly short codes, some long ones, a few above the cap
  function automatic logic [5:0] random_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 6'($urandom_range(8, 1));
    if (r < 85) return 6'($urandom_range(16, 9));
    if (r < 95) return 6'($urandom_range(32, 17));
    return 6'($urandom_range(63, 33));
  endfunction

  // Well-formed traffic on the loaded symbol pool, with some noise
  function automatic in_t random_item();
    int unsigned r;
    logic [7:0]  sym;
    r   = $urandom_range(99);
    sym = ($urandom_range(99) < 85) ? pool[$urandom_range(15)] : 8'($urandom());
    if (r < 12) return pack_item(FUNC_LOAD, sym, $urandom(), random_length());
    if (r < 14) return pack_item(FUNC_LOAD, sym, $urandom(), 6'd0);
    if (r < 88) return pack_item(FUNC_ENCODE, sym, $urandom(), 6'($urandom()));
    if (r < 97) return pack_item(FUNC_FLUSH, sym, $urandom(), 6'($urandom()));
    return pack_item(FUNC_UNUSED, sym, $urandom(), 6'($urandom()));
  endfunction

  // Offer one transaction, idle at random before it, hold until accepted
  task automatic send_item(in_t item);
    while (!no_gaps && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    board.note_accepted_item(item);
  endtask

  // Receiver: check accepted bytes, stall at random, one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
        board.check_emitted_byte(out_data_o);
      if (hold_request && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !no_gaps && ($urandom_range(99) < 7);
      end
    end
  end

  // End the run when neither side has moved for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    no_gaps      = 0;
    hold_request = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, nothing pending, unused operation
    send_item(pack_item(FUNC_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F));
    send_item(pack_item(FUNC_FLUSH, 8'hFF, 32'h0, 6'h00));
    send_item(pack_item(FUNC_UNUSED, 8'hA5, 32'h5A5A_A5A5, 6'h2A));
    // Loads: stray high bits, full width, one bit, lengths above the cap
    send_item(pack_item(FUNC_LOAD, 8'h41, 32'hFFFF_FFFD, 6'd3));
    send_item(pack_item(FUNC_LOAD, 8'hFF, 32'hA5C3_0F96, 6'd32));
    send_item(pack_item(FUNC_LOAD, 8'h00, 32'h0000_0000, 6'd1));
    send_item(pack_item(FUNC_LOAD, 8'h80, 32'h1234_5678, 6'h3F));
    send_item(pack_item(FUNC_LOAD, 8'h10, 32'h0000_005A, 6'd8));
    send_item(pack_item(FUNC_LOAD, 8'h20, 32'hDEAD_BEEF, 6'd33));
    // Encode across byte boundaries, up to four bytes at once
    send_item(pack_item(FUNC_ENCODE, 8'h41, 32'h0, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'h00, 32'h0, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'h80, 32'h0, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'h20, 32'h0, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'h10, 32'h0, 6'd0));
    send_item(pack_item(FUNC_FLUSH, 8'h00, 32'h0, 6'd0));
    send_item(pack_item(FUNC_FLUSH, 8'h00, 32'h0, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'h10, 32'h0, 6'd0));
    // Remove a code, then encode the symbol without one
    send_item(pack_item(FUNC_LOAD, 8'h41, 32'h0000_0007, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'h41, 32'h0, 6'd0));
    // Seven pending bits, then the widest append
    send_item(pack_item(FUNC_LOAD, 8'h20, 32'h0000_007F, 6'd7));
    send_item(pack_item(FUNC_ENCODE, 8'h20, 32'h0, 6'd0));
    send_item(pack_item(FUNC_ENCODE, 8'hFF, 32'h0, 6'd0));
    send_item(pack_item(FUNC_FLUSH, 8'h00, 32'h0, 6'd0));

    // Load a random pool of symbols, then run mixed traffic on it
    for (int k = 0; k < 16; k++) begin
      pool[k] = 8'($urandom());
      send_item(pack_item(FUNC_LOAD, pool[k], $urandom(), random_length()));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 60) hold_request = 1;
      no_gaps = (n >= 120 && n < 220);
      send_item(random_item());
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for anything late or extra
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
